// ===== design/wwgp_pkg.sv =====
// ----------------------------------------------------------------------------
// wwgp_pkg
// Shared sizes, codes, queue item type and saturation helper of the word-wrap
// glyph placer.
// ----------------------------------------------------------------------------
package wwgp_pkg;

  localparam int GLYPH_CODES  = 256;
  localparam int KERN_ENTRIES = 64;
  localparam int WORD_MAX     = 32;
  localparam int QDEPTH       = 4;

  localparam int GI_W = $clog2(GLYPH_CODES);
  localparam int KI_W = (KERN_ENTRIES > 1) ? $clog2(KERN_ENTRIES) : 1;
  localparam int KC_W = $clog2(KERN_ENTRIES + 1);
  localparam int WI_W = $clog2(WORD_MAX);
  localparam int WL_W = $clog2(WORD_MAX + 1);
  localparam int QI_W = $clog2(QDEPTH);
  localparam int QC_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_GLOAD = 2'd1;
  localparam logic [1:0] OP_KLOAD = 2'd2;

  localparam logic [1:0] REG_LINE_HEIGHT = 2'd0;
  localparam logic [1:0] REG_BASELINE    = 2'd1;
  localparam logic [1:0] REG_MAX_WIDTH   = 2'd2;
  localparam logic [1:0] REG_FALLBACK    = 2'd3;

  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_SPACE   = 8'd32;
  localparam logic [7:0] CODE_TAB     = 8'd9;
  localparam logic [7:0] CODE_CR      = 8'd13;

  localparam logic KIND_GLYPH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    CMD_WORD,
    CMD_SPACE,
    CMD_GLOAD,
    CMD_KLOAD
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [7:0]         code;
    logic               eot;
    logic signed [15:0] value;
    logic [7:0]         second;
  } qitem_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [QC_W-1:0] count;
  } qstat_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v[16] != v[15]) begin
      r = v[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== design/word_wrap_glyph_placer.sv =====
// ----------------------------------------------------------------------------
// word_wrap_glyph_placer
// Greedy word-wrap glyph placer: front classifier, command queue, back engine.
// ----------------------------------------------------------------------------
// Back engine: a word character is read and accumulated, a glyph load is written, and a
// kerning load searches the pairs, appending when none matches. A flush kerns each glyph
// against a previous code, emits and advances it; a blank then emits itself, a newline
// moves the pen down. A waiting result holds the back engine until the output slot frees.
// Throughput: the front takes an item a cycle until the 4-entry queue fills.
// Reset (synchronous): pen, box, word, fill count and glyph present bits clear.
module word_wrap_glyph_placer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic [7:0]          char_code,
  input  logic                end_of_text,
  input  logic signed [15:0]  advance_value,
  input  logic [7:0]          second_code,
  input  logic signed [15:0]  kern_amount,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output logic [7:0]          glyph_code,
  output logic signed [15:0]  pos_x,
  output logic signed [15:0]  pos_y,
  output logic signed [15:0]  box_min_x,
  output logic signed [15:0]  box_min_y,
  output logic signed [15:0]  box_max_x,
  output logic signed [15:0]  box_max_y,
  output logic                last
);

  wwgp_pkg::qstat_t q_stat;
  wwgp_pkg::qitem_t push_item;
  wwgp_pkg::qitem_t head;
  logic             push;
  logic             pop;

  wwgp_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .char_code     (char_code),
    .end_of_text   (end_of_text),
    .advance_value (advance_value),
    .second_code   (second_code),
    .kern_amount   (kern_amount),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item)
  );

  wwgp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  wwgp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .glyph_code   (glyph_code),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .box_min_x    (box_min_x),
    .box_min_y    (box_min_y),
    .box_max_x    (box_max_x),
    .box_max_y    (box_max_y),
    .last         (last)
  );

  a_qcount: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= wwgp_pkg::QC_W'(wwgp_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !in_ready)
    else $error("input taken with full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == wwgp_pkg::KIND_SUMMARY) |-> last)
    else $error("summary not marked last");

endmodule

// ===== design/wwgp_front.sv =====
// ----------------------------------------------------------------------------
// wwgp_front
// Accepts input items, classifies them and pushes commands into the queue.
// ----------------------------------------------------------------------------
module wwgp_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic [7:0]          char_code,
  input  logic                end_of_text,
  input  logic signed [15:0]  advance_value,
  input  logic [7:0]          second_code,
  input  logic signed [15:0]  kern_amount,
  input  wwgp_pkg::qstat_t    q_stat,
  output logic                push,
  output wwgp_pkg::qitem_t    push_item
);

  logic is_space;

  assign in_ready = !q_stat.full;
  assign is_space = (char_code == wwgp_pkg::CODE_SPACE) ||
                    ((char_code >= wwgp_pkg::CODE_TAB) && (char_code <= wwgp_pkg::CODE_CR));

  // drop unknown ops here: they cause nothing
  assign push = in_valid && in_ready &&
                ((op == wwgp_pkg::OP_CHAR) || (op == wwgp_pkg::OP_GLOAD) ||
                 (op == wwgp_pkg::OP_KLOAD));

  always_comb begin
    push_item        = '0;
    push_item.code   = char_code;
    push_item.second = second_code;
    case (op)
      wwgp_pkg::OP_GLOAD: begin
        push_item.cmd   = wwgp_pkg::CMD_GLOAD;
        push_item.value = advance_value;
      end
      wwgp_pkg::OP_KLOAD: begin
        push_item.cmd   = wwgp_pkg::CMD_KLOAD;
        push_item.value = kern_amount;
      end
      default: begin
        push_item.cmd = is_space ? wwgp_pkg::CMD_SPACE : wwgp_pkg::CMD_WORD;
        push_item.eot = end_of_text;
      end
    endcase
  end

endmodule

// ===== design/wwgp_queue.sv =====
// ----------------------------------------------------------------------------
// wwgp_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module wwgp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wwgp_pkg::qitem_t  push_item,
  input  logic              pop,
  output wwgp_pkg::qitem_t  head,
  output wwgp_pkg::qstat_t  q_stat
);

  wwgp_pkg::qitem_t              slots [wwgp_pkg::QDEPTH];
  logic [wwgp_pkg::QI_W-1:0]     wr_ptr;
  logic [wwgp_pkg::QI_W-1:0]     rd_ptr;
  logic [wwgp_pkg::QC_W-1:0]     count;

  assign head         = slots[rd_ptr];
  assign q_stat.count = count;
  assign q_stat.full  = (count == wwgp_pkg::QC_W'(wwgp_pkg::QDEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == wwgp_pkg::QI_W'(wwgp_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == wwgp_pkg::QI_W'(wwgp_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/wwgp_back.sv =====
// ----------------------------------------------------------------------------
// wwgp_back
// Executes queued commands: table loads, word gathering, word flush with
// wrap and kerning, whitespace glyphs and box summaries.
// ----------------------------------------------------------------------------
module wwgp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  wwgp_pkg::qitem_t    head,
  input  wwgp_pkg::qstat_t    q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output logic [7:0]          glyph_code,
  output logic signed [15:0]  pos_x,
  output logic signed [15:0]  pos_y,
  output logic signed [15:0]  box_min_x,
  output logic signed [15:0]  box_min_y,
  output logic signed [15:0]  box_max_x,
  output logic signed [15:0]  box_max_y,
  output logic                last
);

  typedef enum logic [3:0] {
    S_IDLE, S_GLOAD, S_WRD, S_WACC, S_FSTART, S_FNEXT, S_FRD,
    S_KRD, S_KCMP, S_FEMIT, S_FADV, S_SPRD, S_SPEMIT, S_POST
  } state_t;

  state_t state;

  logic [14:0]        line_height;
  logic [14:0]        baseline_to_top;
  logic [14:0]        max_width;
  logic signed [15:0] fallback_advance;

  // glyph table
  logic                     present [wwgp_pkg::GLYPH_CODES];
  logic signed [15:0]       glyph_mem [wwgp_pkg::GLYPH_CODES];
  logic signed [15:0]       glyph_q;
  logic                     present_q;
  logic [7:0]               adv_code;
  logic                     adv_in_range;
  logic [wwgp_pkg::GI_W-1:0] adv_idx;
  logic                     ld_in_range;
  logic [wwgp_pkg::GI_W-1:0] ld_idx;
  logic                     glyph_we;

  // kerning table
  logic [15:0]              kkey_mem [wwgp_pkg::KERN_ENTRIES];
  logic signed [15:0]       kamt_mem [wwgp_pkg::KERN_ENTRIES];
  logic [15:0]              kkey_q;
  logic signed [15:0]       kamt_q;
  logic [wwgp_pkg::KC_W-1:0] fill;
  logic [wwgp_pkg::KC_W-1:0] kidx;
  logic [15:0]              key;
  logic                     kmode_load;
  logic                     kern_we;

  // word buffer
  logic [7:0]               word_mem [wwgp_pkg::WORD_MAX];
  logic [7:0]               word_q;
  logic [wwgp_pkg::WL_W-1:0] len;
  logic [wwgp_pkg::WL_W-1:0] len_n;
  logic [wwgp_pkg::WL_W-1:0] k;
  logic                     word_we;
  logic signed [15:0]       word_width;

  // pen and box
  logic signed [15:0] pen_x;
  logic signed [15:0] pen_y;
  logic               prev_valid;
  logic [7:0]         prev_code;
  logic signed [15:0] bmin_x, bmin_y, bmax_x, bmax_y;

  wwgp_pkg::qitem_t   cur;
  logic [7:0]         gc;

  logic signed [15:0] adv;
  logic signed [15:0] y_base;
  logic signed [15:0] y_line;
  logic signed [15:0] px_adv;
  logic signed [16:0] wrap_sum;
  logic               wrap;
  logic               slot_free;
  logic               glyph_last;

  assign pop          = (state == S_IDLE) && !q_stat.empty;
  assign slot_free    = !out_valid || out_ready;
  assign adv_in_range = ({1'b0, adv_code} < 9'(wwgp_pkg::GLYPH_CODES));
  assign adv_idx      = adv_code[wwgp_pkg::GI_W-1:0];
  assign ld_in_range  = ({1'b0, cur.code} < 9'(wwgp_pkg::GLYPH_CODES));
  assign ld_idx       = cur.code[wwgp_pkg::GI_W-1:0];
  assign glyph_we     = (state == S_GLOAD) && ld_in_range && !present[ld_idx];
  assign kern_we      = (state == S_KRD) && (kidx == fill) && kmode_load &&
                        (fill < wwgp_pkg::KC_W'(wwgp_pkg::KERN_ENTRIES));
  assign word_we      = (state == S_WACC) && (len < wwgp_pkg::WL_W'(wwgp_pkg::WORD_MAX));
  assign len_n        = word_we ? len + 1'b1 : len;

  assign adv      = present_q ? glyph_q : fallback_advance;
  assign y_base   = wwgp_pkg::sat16({pen_y[15], pen_y} - {2'b00, baseline_to_top});
  assign y_line   = wwgp_pkg::sat16({pen_y[15], pen_y} - {2'b00, line_height});
  assign px_adv   = wwgp_pkg::sat16({pen_x[15], pen_x} + {adv[15], adv});
  assign wrap_sum = {pen_x[15], pen_x} + {word_width[15], word_width};
  assign wrap     = wrap_sum > $signed({2'b00, max_width});
  // the newline and a word-full flush end with the word's last glyph
  assign glyph_last = (wwgp_pkg::WL_W'(k + 1'b1) == len) && !cur.eot &&
                      ((cur.cmd == wwgp_pkg::CMD_WORD) || (cur.code == wwgp_pkg::CODE_NEWLINE));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wwgp_pkg::GLYPH_CODES; i++) begin
        present[i] <= 1'b0;
      end
    end else if (glyph_we) begin
      present[ld_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[ld_idx] <= cur.value;
    end
    glyph_q   <= glyph_mem[adv_idx];
    present_q <= adv_in_range && present[adv_idx];
  end

  always_ff @(posedge clk) begin
    if (kern_we) begin
      kkey_mem[fill[wwgp_pkg::KI_W-1:0]] <= key;
      kamt_mem[fill[wwgp_pkg::KI_W-1:0]] <= cur.value;
    end
    kkey_q <= kkey_mem[kidx[wwgp_pkg::KI_W-1:0]];
    kamt_q <= kamt_mem[kidx[wwgp_pkg::KI_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[len[wwgp_pkg::WI_W-1:0]] <= cur.code;
    end
    word_q <= word_mem[k[wwgp_pkg::WI_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      line_height      <= '0;
      baseline_to_top  <= '0;
      max_width        <= '0;
      fallback_advance <= '0;
      fill             <= '0;
      len              <= '0;
      word_width       <= '0;
      pen_x            <= '0;
      pen_y            <= '0;
      prev_valid       <= 1'b0;
      bmin_x           <= '0;
      bmin_y           <= '0;
      bmax_x           <= '0;
      bmax_y           <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write_en) begin
        case (cfg_index)
          wwgp_pkg::REG_LINE_HEIGHT: line_height      <= cfg_data[14:0];
          wwgp_pkg::REG_BASELINE:    baseline_to_top  <= cfg_data[14:0];
          wwgp_pkg::REG_MAX_WIDTH:   max_width        <= cfg_data[14:0];
          wwgp_pkg::REG_FALLBACK:    fallback_advance <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            cur      <= head;
            adv_code <= head.code;
            key      <= {head.code, head.second};
            kidx     <= '0;
            case (head.cmd)
              wwgp_pkg::CMD_GLOAD: state <= S_GLOAD;
              wwgp_pkg::CMD_KLOAD: begin
                kmode_load <= 1'b1;
                state      <= S_KRD;
              end
              wwgp_pkg::CMD_WORD:  state <= S_WRD;
              default:             state <= S_FSTART;
            endcase
          end
        end
        S_GLOAD: state <= S_IDLE;
        S_WRD:   state <= S_WACC;
        S_WACC: begin
          len        <= len_n;
          word_width <= wwgp_pkg::sat16({word_width[15], word_width} + {adv[15], adv});
          if ((len_n >= wwgp_pkg::WL_W'(wwgp_pkg::WORD_MAX)) || cur.eot) begin
            state <= S_FSTART;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FSTART: begin
          if (wrap) begin
            pen_x <= '0;
            pen_y <= y_line;
          end
          k     <= '0;
          state <= S_FNEXT;
        end
        S_FNEXT: begin
          if (k == len) begin
            len        <= '0;
            word_width <= '0;
            if (cur.cmd == wwgp_pkg::CMD_SPACE) begin
              prev_code  <= cur.code;
              prev_valid <= 1'b1;
              if (cur.code == wwgp_pkg::CODE_NEWLINE) begin
                pen_x <= '0;
                pen_y <= y_line;
                state <= S_POST;
              end else begin
                adv_code <= cur.code;
                state    <= S_SPRD;
              end
            end else begin
              state <= S_POST;
            end
          end else begin
            state <= S_FRD;
          end
        end
        S_FRD: begin
          gc         <= word_q;
          adv_code   <= word_q;
          key        <= {prev_code, word_q};
          kidx       <= '0;
          kmode_load <= 1'b0;
          state      <= prev_valid ? S_KRD : S_FEMIT;
        end
        S_KRD: begin
          if (kidx == fill) begin
            if (kern_we) begin
              fill <= fill + 1'b1;
            end
            state <= kmode_load ? S_IDLE : S_FEMIT;
          end else begin
            state <= S_KCMP;
          end
        end
        S_KCMP: begin
          if (kkey_q == key) begin
            if (!kmode_load) begin
              pen_x <= wwgp_pkg::sat16({pen_x[15], pen_x} + {kamt_q[15], kamt_q});
            end
            state <= kmode_load ? S_IDLE : S_FEMIT;
          end else begin
            kidx  <= kidx + 1'b1;
            state <= S_KRD;
          end
        end
        S_FEMIT: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            kind       <= wwgp_pkg::KIND_GLYPH;
            glyph_code <= gc;
            pos_x      <= pen_x;
            pos_y      <= y_base;
            box_min_x  <= '0;
            box_min_y  <= '0;
            box_max_x  <= '0;
            box_max_y  <= '0;
            last       <= glyph_last;
            state      <= S_FADV;
          end
        end
        S_FADV: begin
          pen_x <= px_adv;
          if (px_adv < bmin_x) bmin_x <= px_adv;
          if (px_adv > bmax_x) bmax_x <= px_adv;
          if (y_line < bmin_y) bmin_y <= y_line;
          if (y_line > bmax_y) bmax_y <= y_line;
          prev_code  <= gc;
          prev_valid <= 1'b1;
          k          <= k + 1'b1;
          state      <= S_FNEXT;
        end
        S_SPRD: state <= S_SPEMIT;
        S_SPEMIT: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            kind       <= wwgp_pkg::KIND_GLYPH;
            glyph_code <= cur.code;
            pos_x      <= pen_x;
            pos_y      <= y_base;
            box_min_x  <= '0;
            box_min_y  <= '0;
            box_max_x  <= '0;
            box_max_y  <= '0;
            last       <= !cur.eot;
            pen_x      <= px_adv;
            state      <= S_POST;
          end
        end
        S_POST: begin
          if (!cur.eot) begin
            state <= S_IDLE;
          end else if (slot_free) begin
            out_valid  <= 1'b1;
            kind       <= wwgp_pkg::KIND_SUMMARY;
            glyph_code <= '0;
            pos_x      <= '0;
            pos_y      <= '0;
            box_min_x  <= bmin_x;
            box_min_y  <= bmin_y;
            box_max_x  <= bmax_x;
            box_max_y  <= bmax_y;
            last       <= 1'b1;
            pen_x      <= '0;
            pen_y      <= '0;
            prev_valid <= 1'b0;
            bmin_x     <= '0;
            bmin_y     <= '0;
            bmax_x     <= '0;
            bmax_y     <= '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/word_wrap_glyph_placer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// word_wrap_glyph_placer_tb
// Self-checking bench: drives glyph loads, kerning loads and text through the
// item channel, keeps its own layout predictor and compares every placed glyph
// and box summary, field by field, against the oldest predicted result.
// ----------------------------------------------------------------------------
module word_wrap_glyph_placer_tb;

  localparam logic [1:0] OP_NONE   = 2'd3;
  localparam int         SETTLE    = 400;
  localparam int         WDOG_MAX  = 20000;

  typedef struct {
    logic        kind;
    logic [7:0]  code;
    int          x, y, bx0, by0, bx1, by1;
    logic        lst;
  } placement_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_en = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         op = wwgp_pkg::OP_CHAR;
  logic [7:0]         char_code = '0;
  logic               end_of_text = 1'b0;
  logic signed [15:0] advance_value = '0;
  logic [7:0]         second_code = '0;
  logic signed [15:0] kern_amount = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               kind;
  logic [7:0]         glyph_code;
  logic signed [15:0] pos_x, pos_y, box_min_x, box_min_y, box_max_x, box_max_y;
  logic               last;

  word_wrap_glyph_placer u_dut (.*);

  always #5 clk = ~clk;

  // layout state of the predictor
  int         line_h, base_top, wrap_w, fb_adv;
  bit         has_glyph [wwgp_pkg::GLYPH_CODES];
  int         glyph_adv [wwgp_pkg::GLYPH_CODES];
  logic [15:0] kpair_key [wwgp_pkg::KERN_ENTRIES];
  int         kpair_amt [wwgp_pkg::KERN_ENTRIES];
  int         kpair_cnt;
  logic [7:0] word_buf [wwgp_pkg::WORD_MAX];
  int         word_len, word_w, pen_x, pen_y;
  bit         prev_ok;
  logic [7:0] prev_code;
  int         box [4];

  placement_t placement_q[$];
  placement_t burst_q[$];
  int         fail_count = 0;
  bit         steady = 0;
  int         hold_request = 0;

  function automatic int sat16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == wwgp_pkg::CODE_SPACE ||
           (c >= wwgp_pkg::CODE_TAB && c <= wwgp_pkg::CODE_CR);
  endfunction

  function automatic int advance_for(logic [7:0] c);
    return has_glyph[c] ? glyph_adv[c] : fb_adv;
  endfunction

  function automatic int kern_for(logic [7:0] a, logic [7:0] b);
    for (int k = 0; k < kpair_cnt; k++)
      if (kpair_key[k] == {a, b}) return kpair_amt[k];
    return 0;
  endfunction

  function automatic void place(logic k, logic [7:0] c, int x, int y, bit with_box);
    placement_t p;
    p.kind = k; p.code = c; p.x = x; p.y = y; p.lst = 1'b0;
    p.bx0 = with_box ? box[0] : 0;
    p.by0 = with_box ? box[1] : 0;
    p.bx1 = with_box ? box[2] : 0;
    p.by1 = with_box ? box[3] : 0;
    burst_q.push_back(p);
  endfunction

  function automatic void next_line();
    pen_x = 0;
    pen_y = sat16(pen_y - line_h);
  endfunction

  function automatic void flush_word();
    int gy;
    if (pen_x + word_w > wrap_w) next_line();
    for (int k = 0; k < word_len; k++) begin
      if (prev_ok) pen_x = sat16(pen_x + kern_for(prev_code, word_buf[k]));
      place(wwgp_pkg::KIND_GLYPH, word_buf[k], pen_x, sat16(pen_y - base_top), 0);
      pen_x = sat16(pen_x + advance_for(word_buf[k]));
      gy = sat16(pen_y - line_h);
      if (pen_x < box[0]) box[0] = pen_x;
      if (gy < box[1]) box[1] = gy;
      if (pen_x > box[2]) box[2] = pen_x;
      if (gy > box[3]) box[3] = gy;
      prev_code = word_buf[k];
      prev_ok = 1;
    end
    word_len = 0;
    word_w = 0;
  endfunction

  // update the layout state for one accepted item and queue its results
  function automatic void predict_layout(logic [1:0] o, logic [7:0] c, logic e,
                                         logic signed [15:0] a, logic [7:0] s,
                                         logic signed [15:0] kamt);
    bit dup;
    burst_q.delete();
    case (o)
      wwgp_pkg::OP_GLOAD: begin
        if (!has_glyph[c]) begin
          has_glyph[c] = 1;
          glyph_adv[c] = a;
        end
      end
      wwgp_pkg::OP_KLOAD: begin
        dup = 0;
        for (int k = 0; k < kpair_cnt; k++) if (kpair_key[k] == {c, s}) dup = 1;
        if (!dup && kpair_cnt < wwgp_pkg::KERN_ENTRIES) begin
          kpair_key[kpair_cnt] = {c, s};
          kpair_amt[kpair_cnt] = kamt;
          kpair_cnt++;
        end
      end
      wwgp_pkg::OP_CHAR: begin
        if (is_blank(c)) begin
          flush_word();
          if (c == wwgp_pkg::CODE_NEWLINE) next_line();
          else begin
            place(wwgp_pkg::KIND_GLYPH, c, pen_x, sat16(pen_y - base_top), 0);
            pen_x = sat16(pen_x + advance_for(c));
          end
          prev_code = c;
          prev_ok = 1;
        end else begin
          if (word_len < wwgp_pkg::WORD_MAX) word_buf[word_len++] = c;
          word_w = sat16(word_w + advance_for(c));
          if (word_len >= wwgp_pkg::WORD_MAX || e) flush_word();
        end
        if (e) begin
          place(wwgp_pkg::KIND_SUMMARY, '0, 0, 0, 1);
          pen_x = 0; pen_y = 0; prev_ok = 0; prev_code = '0;
          box = '{0, 0, 0, 0};
        end
      end
      default: ;
    endcase
    if (burst_q.size() > 0) burst_q[burst_q.size()-1].lst = 1'b1;
    foreach (burst_q[i]) placement_q.push_back(burst_q[i]);
  endfunction

  // ---------------- item channel ----------------
  task automatic send_item(logic [1:0] o, logic [7:0] c, logic e,
                           logic signed [15:0] a, logic [7:0] s,
                           logic signed [15:0] kamt);
    int gap;
    gap = (!steady && $urandom_range(99) < 33) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o; char_code <= c; end_of_text <= e;
    advance_value <= a; second_code <= s; kern_amount <= kamt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_layout(o, c, e, a, s, kamt);
  endtask

  task automatic send_char(logic [7:0] c, logic e = 1'b0);
    send_item(wwgp_pkg::OP_CHAR, c, e, 16'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic send_glyph(logic [7:0] c, logic signed [15:0] a);
    send_item(wwgp_pkg::OP_GLOAD, c, 1'($urandom), a, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_kern(logic [7:0] c, logic [7:0] s, logic signed [15:0] kamt);
    send_item(wwgp_pkg::OP_KLOAD, c, 1'($urandom), 16'($urandom), s, kamt);
  endtask

  task automatic send_text(string txt, logic e);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i], e && i == txt.len() - 1);
  endtask

  // drop valid, wait for every result, then let the kerning search settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(int lh, int bl, int mw, int fb);
    int v [4];
    v = '{lh, bl, mw, fb};
    for (int i = 0; i < 4; i++) begin
      cfg_write_en <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= v[i][15:0];
      @(posedge clk);
    end
    cfg_write_en <= 1'b0;
    line_h   = lh & 16'h7FFF;
    base_top = bl & 16'h7FFF;
    wrap_w   = mw & 16'h7FFF;
    fb_adv   = int'($signed(fb[15:0]));
  endtask

  // ---------------- result channel ----------------
  int hold_left = 0;
  always @(posedge clk) begin
    placement_t p;
    if (!rst && out_valid && out_ready) begin
      if (placement_q.size() == 0) begin
        $error("unexpected result: kind %0d code %0d", kind, glyph_code);
        fail_count++;
      end else begin
        p = placement_q.pop_front();
        if (kind !== p.kind) begin
          $error("kind: expected %0d, got %0d", p.kind, kind); fail_count++;
        end
        if (glyph_code !== p.code) begin
          $error("glyph_code: expected %0d, got %0d", p.code, glyph_code); fail_count++;
        end
        if (pos_x !== p.x[15:0]) begin
          $error("pos_x: expected %0d, got %0d", p.x, pos_x); fail_count++;
        end
        if (pos_y !== p.y[15:0]) begin
          $error("pos_y: expected %0d, got %0d", p.y, pos_y); fail_count++;
        end
        if (box_min_x !== p.bx0[15:0]) begin
          $error("box_min_x: expected %0d, got %0d", p.bx0, box_min_x); fail_count++;
        end
        if (box_min_y !== p.by0[15:0]) begin
          $error("box_min_y: expected %0d, got %0d", p.by0, box_min_y); fail_count++;
        end
        if (box_max_x !== p.bx1[15:0]) begin
          $error("box_max_x: expected %0d, got %0d", p.bx1, box_max_x); fail_count++;
        end
        if (box_max_y !== p.by1[15:0]) begin
          $error("box_max_y: expected %0d, got %0d", p.by1, box_max_y); fail_count++;
        end
        if (last !== p.lst) begin
          $error("last: expected %0d, got %0d", p.lst, last); fail_count++;
        end
      end
    end
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || $urandom_range(99) >= 33;
    end
  end

  // abort when nothing moves on either channel for too long
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_MAX) begin
      $display("** word_wrap_glyph_placer: FAILED **");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_reset_defaults();
    // zero registers: every advance is 0, so nothing wraps and the box stays at 0
    send_text("ab c", 1'b1);
    wait_idle();
    set_config(10, 8, 100, 5);
  endtask

  task automatic test_loads();
    send_glyph("a", 7);
    send_glyph("a", 99);            // later load of the same code is ignored
    send_glyph("b", 9);
    send_glyph(8'd0, 16'sh7FFF);
    send_glyph(8'd255, 16'sh8000);
    send_glyph(wwgp_pkg::CODE_SPACE, 4);
    send_kern("a", "b", -2);
    send_kern("a", "b", 50);        // duplicate pair
    send_kern(wwgp_pkg::CODE_SPACE, "a", 16'sh7FFF);
    send_item(OP_NONE, 8'hFF, 1'b1, 16'shFFFF, 8'hFF, 16'shFFFF);
  endtask

  task automatic test_text_cases();
    send_text("ab", 1'b0);
    send_char(wwgp_pkg::CODE_SPACE);
    send_char(wwgp_pkg::CODE_SPACE);   // blank with an empty word
    send_text("ba\tab", 1'b0);
    send_char(wwgp_pkg::CODE_NEWLINE);
    send_char(8'd11);
    send_char(8'd12);
    send_char(wwgp_pkg::CODE_CR);
    send_char(8'd0);
    send_char(8'd255, 1'b1);
    // send one code more than the word buffer holds
    for (int i = 0; i <= wwgp_pkg::WORD_MAX; i++) send_char("a", i == wwgp_pkg::WORD_MAX);
  endtask

  task automatic test_saturation();
    wait_idle();
    set_config(32767, 32767, 32767, 32767);
    send_text("zz z\n\nq", 1'b1);
    wait_idle();
    set_config(0, 0, 0, -32768);
    send_text("yy y", 1'b1);
  endtask

  task automatic test_backpressure();
    wait_idle();
    set_config(12, 3, 80, 6);
    hold_request = 400;
    for (int i = 0; i < 12; i++)
      send_char((i % 4 == 3) ? wwgp_pkg::CODE_SPACE : 8'("a" + i % 3));
    send_char("b", 1'b1);
    wait_idle();                    // sender stops until every result is back
  endtask

  task automatic test_kern_many();
    for (int i = 0; i < 12; i++)
      send_kern(8'("c" + i % 4), 8'(i + 40), 16'($urandom_range(0, 6) - 3));
  endtask

  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 8'("a" + $urandom_range(0, 7));
    if (r < 80) return $urandom_range(0, 1) ? wwgp_pkg::CODE_SPACE : 8'($urandom_range(9, 13));
    if (r < 87) return wwgp_pkg::CODE_NEWLINE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_random_phase(int n, int lh, int bl, int mw, int fb);
    int r;
    wait_idle();
    set_config(lh, bl, mw, fb);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 6) send_glyph(8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 20)));
      else if (r < 11) send_kern(8'("a" + $urandom_range(0, 7)), 8'("a" + $urandom_range(0, 7)),
                                 16'($urandom_range(0, 3) == 0 ? $urandom
                                                               : $urandom_range(0, 8) - 4));
      else if (r < 13) send_item(OP_NONE, 8'($urandom), 1'($urandom), 16'($urandom),
                                 8'($urandom), 16'($urandom));
      else send_char(pick_code(), $urandom_range(0, 11) == 0);
    end
    send_char("e", 1'b1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_loads();
    test_text_cases();
    test_saturation();
    test_backpressure();
    test_random_phase(4, 10, 8, 60, 6);
    steady = 1;
    test_random_phase(8, 32767, 32767, 0, -32768);
    steady = 0;
    test_kern_many();
    test_random_phase(3, 0, 0, 32767, 32767);
    test_random_phase(3, $urandom_range(0, 32767), $urandom_range(0, 32767),
                      $urandom_range(0, 200), $urandom_range(0, 30));
    wait_idle();
    if (fail_count == 0) begin
      $display("** word_wrap_glyph_placer: PASSED **");
    end else begin
      $display("** word_wrap_glyph_placer: FAILED **");
    end
    $finish;
  end

endmodule
